FILE: hdl/knps_pkg.sv
// ---------------------------------------------------------------------------
// knps_pkg
// Shared codes and types of the k-nearest point selector.
// ---------------------------------------------------------------------------
package knps_pkg;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_ROOT,
    ST_EMIT
  } state_t;

endpackage

FILE: hdl/knps_ram.sv
// ---------------------------------------------------------------------------
// knps_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module knps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/knps_front.sv
// ---------------------------------------------------------------------------
// knps_front
// Input side: accepts items, clamps the neighbour count, queues commands.
// ---------------------------------------------------------------------------
module knps_front #(
  parameter int MAX_POINTS = 1024,
  parameter int MAX_K      = 16,
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_op,
  input  logic [$clog2(MAX_POINTS)-1:0]       in_point_index,
  input  logic signed [COORD_BITS-1:0]        in_coord_x,
  input  logic signed [COORD_BITS-1:0]        in_coord_y,
  input  logic signed [COORD_BITS-1:0]        in_coord_z,
  input  logic [$clog2(MAX_K+1)-1:0]          in_neighbour_count,
  input  logic [$clog2(MAX_POINTS+1)-1:0]     point_count,
  output logic                                cmd_valid,
  input  logic                                cmd_pop,
  output logic                                cmd_op,
  output logic [$clog2(MAX_POINTS)-1:0]       cmd_index,
  output logic signed [COORD_BITS-1:0]        cmd_x,
  output logic signed [COORD_BITS-1:0]        cmd_y,
  output logic signed [COORD_BITS-1:0]        cmd_z,
  output logic [$clog2(MAX_K+1)-1:0]          cmd_k
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int KW    = $clog2(MAX_K+1);
  localparam int PW    = 1 + IDX_W + 3*COORD_BITS + KW;

  logic [PW-1:0] q_r [2];
  logic          wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push;
  logic [KW-1:0] k_clamp;
  int            n_int, k_int;

  always_comb begin
    n_int = (32'(point_count) > MAX_POINTS) ? MAX_POINTS : 32'(point_count);
    k_int = 32'(in_neighbour_count);
    if (k_int > n_int) begin
      k_int = n_int;
    end
    if (k_int > MAX_K) begin
      k_int = MAX_K;
    end
    k_clamp = KW'(k_int);
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = cmd_pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= {in_op, in_point_index, in_coord_x, in_coord_y, in_coord_z, k_clamp};
    end
  end

  assign {cmd_op, cmd_index, cmd_x, cmd_y, cmd_z, cmd_k} = q_r[rp_r];

endmodule

FILE: hdl/knps_back.sv
// ---------------------------------------------------------------------------
// knps_back
// Execution side: point table writes, distance scan with sorted candidate
// list, bit-serial square root and result emission.
// ---------------------------------------------------------------------------
module knps_back #(
  parameter int MAX_POINTS = 1024,
  parameter int MAX_K      = 16,
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [$clog2(MAX_POINTS+1)-1:0]     point_count,
  input  logic                                cmd_valid,
  output logic                                cmd_pop,
  input  logic                                cmd_op,
  input  logic [$clog2(MAX_POINTS)-1:0]       cmd_index,
  input  logic signed [COORD_BITS-1:0]        cmd_x,
  input  logic signed [COORD_BITS-1:0]        cmd_y,
  input  logic signed [COORD_BITS-1:0]        cmd_z,
  input  logic [$clog2(MAX_K+1)-1:0]          cmd_k,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [$clog2(MAX_POINTS)-1:0]       out_found_index,
  output logic [COORD_BITS:0]                 out_distance,
  output logic                                out_last
);

  localparam int CB    = COORD_BITS;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS+1);
  localparam int KW    = $clog2(MAX_K+1);
  localparam int SEL_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int RW    = CB + 1;
  localparam int SQ_W  = 2*RW;
  localparam int IT_W  = $clog2(RW);

  knps_pkg::state_t state_r, state_nxt;

  logic signed [CB-1:0] qx_r, qy_r, qz_r;
  logic [KW-1:0]        k_r, pos_r;
  logic [CNT_W-1:0]     n_r;
  logic [IDX_W-1:0]     scan_r;
  logic                 v1_r, v2_r, v3_r, v4_r;
  logic [IDX_W-1:0]     idx1_r, idx2_r, idx3_r, idx4_r;
  logic [CB-1:0]        dx_r, dy_r, dz_r;
  logic [2*CB-1:0]      sx_r, sy_r, sz_r;
  logic [SQ_W-1:0]      sum_r;
  logic [SQ_W-1:0]      best_d_r [MAX_K];
  logic [IDX_W-1:0]     best_i_r [MAX_K];
  logic [SQ_W-1:0]      best_d_nxt [MAX_K];
  logic [IDX_W-1:0]     best_i_nxt [MAX_K];
  logic [SQ_W-1:0]      opnd_r;
  logic [RW-1:0]        root_r, root_nxt;
  logic [RW:0]          rem_r, rem_nxt;
  logic [RW+2:0]        rem_sh, trial;
  logic [IT_W-1:0]      it_r;
  logic [IDX_W-1:0]     cur_idx_r;
  logic                 cur_last_r;
  logic [IDX_W-1:0]     out_idx_r;
  logic [RW-1:0]        out_dist_r;
  logic                 out_last_r, out_valid_r;

  logic                 is_write, start_search, scan_done, pipe_empty;
  logic                 root_done, out_take, load_root;
  logic [KW-1:0]        sel_pos, sel;
  logic [CNT_W-1:0]     n_clamp;
  logic [3*CB-1:0]      rd_data;
  logic                 ram_we;
  logic [MAX_K:0]       ge_ext, gt_ext;
  logic                 fill, repl;

  // ------------------------------------------------------------ control
  assign is_write     = cmd_valid && (cmd_op == knps_pkg::OP_WRITE);
  assign start_search = cmd_valid && (cmd_op == knps_pkg::OP_SEARCH) && (cmd_k != '0);
  assign scan_done    = (CNT_W'(scan_r) + CNT_W'(1)) == n_r;
  assign pipe_empty   = !v1_r && !v2_r && !v3_r && !v4_r;
  assign root_done    = (it_r == IT_W'(RW-1));
  assign out_take     = out_valid_r && !out_stall;
  assign n_clamp      = (32'(point_count) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : point_count;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      knps_pkg::ST_IDLE:  if (start_search) state_nxt = knps_pkg::ST_SCAN;
      knps_pkg::ST_SCAN:  if (scan_done) state_nxt = knps_pkg::ST_DRAIN;
      knps_pkg::ST_DRAIN: if (pipe_empty) state_nxt = knps_pkg::ST_ROOT;
      knps_pkg::ST_ROOT:  if (root_done) state_nxt = knps_pkg::ST_EMIT;
      knps_pkg::ST_EMIT: begin
        if (out_take) begin
          state_nxt = out_last_r ? knps_pkg::ST_IDLE : knps_pkg::ST_ROOT;
        end
      end
      default: state_nxt = knps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop   = 1'b0;
    ram_we    = 1'b0;
    load_root = 1'b0;
    unique case (state_r)
      knps_pkg::ST_IDLE: begin
        cmd_pop = cmd_valid;
        ram_we  = is_write && (32'(cmd_index) < MAX_POINTS);
      end
      knps_pkg::ST_DRAIN: load_root = pipe_empty;
      knps_pkg::ST_EMIT:  load_root = out_take && !out_last_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= knps_pkg::ST_IDLE;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      v1_r        <= (state_r == knps_pkg::ST_SCAN);
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= (state_nxt == knps_pkg::ST_EMIT);
    end
  end

  // ------------------------------------------------------------ point table
  knps_ram #(
    .WIDTH (3*CB),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cmd_index),
    .wdata ({cmd_x, cmd_y, cmd_z}),
    .raddr (scan_r),
    .rdata (rd_data)
  );

  // ------------------------------------------------------------ distance pipe
  function automatic logic [CB-1:0] abs_diff(input logic signed [CB-1:0] a,
                                             input logic signed [CB-1:0] b);
    logic signed [CB:0] d;
    d = {a[CB-1], a} - {b[CB-1], b};
    abs_diff = d[CB] ? CB'(-d) : CB'(d);
  endfunction

  always_ff @(posedge clk) begin
    if (state_r == knps_pkg::ST_IDLE && start_search) begin
      qx_r   <= cmd_x;
      qy_r   <= cmd_y;
      qz_r   <= cmd_z;
      k_r    <= cmd_k;
      n_r    <= n_clamp;
      scan_r <= '0;
    end else if (state_r == knps_pkg::ST_SCAN) begin
      scan_r <= scan_r + IDX_W'(1);
    end
    idx1_r <= scan_r;
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    idx4_r <= idx3_r;
    dx_r   <= abs_diff(rd_data[3*CB-1:2*CB], qx_r);
    dy_r   <= abs_diff(rd_data[2*CB-1:CB], qy_r);
    dz_r   <= abs_diff(rd_data[CB-1:0], qz_r);
    sx_r   <= dx_r * dx_r;
    sy_r   <= dy_r * dy_r;
    sz_r   <= dz_r * dz_r;
    sum_r  <= SQ_W'(sx_r) + SQ_W'(sy_r) + SQ_W'(sz_r);
  end

  // ------------------------------------------------------------ candidate list
  // list is kept descending: position 0 holds the worst candidate
  always_comb begin
    fill = 32'(idx4_r) < 32'(k_r);
    repl = !fill && (sum_r < best_d_r[0]);
    ge_ext[0]     = 1'b1;
    gt_ext[MAX_K] = 1'b0;
    for (int j = 0; j < MAX_K; j++) begin
      ge_ext[j+1] = (j < 32'(idx4_r)) && (best_d_r[j] >= sum_r);
      gt_ext[j]   = (j < 32'(k_r)) && (best_d_r[j] > sum_r);
    end
    for (int j = 0; j < MAX_K; j++) begin
      best_d_nxt[j] = best_d_r[j];
      best_i_nxt[j] = best_i_r[j];
      if (v4_r && fill && !ge_ext[j+1]) begin
        // new point lands after existing equals
        if (ge_ext[j]) begin
          best_d_nxt[j] = sum_r;
          best_i_nxt[j] = idx4_r;
        end else begin
          best_d_nxt[j] = best_d_r[(j == 0) ? 0 : j-1];
          best_i_nxt[j] = best_i_r[(j == 0) ? 0 : j-1];
        end
      end else if (v4_r && repl) begin
        // worst dropped, new point stops in front of equals
        if (gt_ext[j+1]) begin
          best_d_nxt[j] = best_d_r[(j == MAX_K-1) ? j : j+1];
          best_i_nxt[j] = best_i_r[(j == MAX_K-1) ? j : j+1];
        end else if (gt_ext[j]) begin
          best_d_nxt[j] = sum_r;
          best_i_nxt[j] = idx4_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_K; j++) begin
      best_d_r[j] <= best_d_nxt[j];
      best_i_r[j] <= best_i_nxt[j];
    end
  end

  // ------------------------------------------------------------ square root
  assign sel_pos = (state_r == knps_pkg::ST_EMIT) ? pos_r + KW'(1) : pos_r;
  assign sel     = k_r - KW'(1) - sel_pos;

  always_comb begin
    rem_sh = {rem_r, opnd_r[SQ_W-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt  = (RW+1)'(rem_sh - trial);
      root_nxt = {root_r[RW-2:0], 1'b1};
    end else begin
      rem_nxt  = (RW+1)'(rem_sh);
      root_nxt = {root_r[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == knps_pkg::ST_IDLE) begin
      pos_r <= '0;
    end else if (out_take) begin
      pos_r <= pos_r + KW'(1);
    end
    if (load_root) begin
      opnd_r     <= best_d_r[sel[SEL_W-1:0]];
      cur_idx_r  <= best_i_r[sel[SEL_W-1:0]];
      cur_last_r <= (sel == '0);
      root_r     <= '0;
      rem_r      <= '0;
      it_r       <= '0;
    end else if (state_r == knps_pkg::ST_ROOT) begin
      opnd_r <= {opnd_r[SQ_W-3:0], 2'b00};
      root_r <= root_nxt;
      rem_r  <= rem_nxt;
      it_r   <= it_r + IT_W'(1);
      if (root_done) begin
        out_idx_r  <= cur_idx_r;
        out_dist_r <= root_nxt;
        out_last_r <= cur_last_r;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found_index = out_idx_r;
  assign out_distance    = out_dist_r;
  assign out_last        = out_last_r;

endmodule

FILE: hdl/k_nearest_point_selector_core.sv
// ---------------------------------------------------------------------------
// k_nearest_point_selector_core
// k-nearest neighbour search over a table of 3D fixed-point points.
// ---------------------------------------------------------------------------
// Op 0 writes one point into the table while the execution side is idle.
// Op 1 scans the first point_count table entries, one per
// cycle through the table's read port, then drains the distance pipe
// and produces k results, each through a bit-serial square root of
// COORD_BITS+1 bits and an output step that holds while the receiver stalls.
// The search time is set by the single read port and the one-bit-per-cycle
// root, and by receiver stalls. A two-entry command queue accepts items
// while a search runs until both of its entries are full.
module k_nearest_point_selector_core #(
  parameter int MAX_POINTS = 1024,
  parameter int MAX_K      = 16,
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [$clog2(MAX_POINTS+1)-1:0]     cfg_point_count,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_op,
  input  logic [$clog2(MAX_POINTS)-1:0]       in_point_index,
  input  logic signed [COORD_BITS-1:0]        in_coord_x,
  input  logic signed [COORD_BITS-1:0]        in_coord_y,
  input  logic signed [COORD_BITS-1:0]        in_coord_z,
  input  logic [$clog2(MAX_K+1)-1:0]          in_neighbour_count,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [$clog2(MAX_POINTS)-1:0]       out_found_index,
  output logic [COORD_BITS:0]                 out_distance,
  output logic                                out_last
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS+1);
  localparam int KW    = $clog2(MAX_K+1);

  logic [CNT_W-1:0]            point_count_r;
  logic                        cmd_valid, cmd_pop, cmd_op;
  logic [IDX_W-1:0]            cmd_index;
  logic signed [COORD_BITS-1:0] cmd_x, cmd_y, cmd_z;
  logic [KW-1:0]               cmd_k;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= '0;
    end else if (cfg_we) begin
      point_count_r <= cfg_point_count;
    end
  end

  knps_front #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_K      (MAX_K),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_point_index     (in_point_index),
    .in_coord_x         (in_coord_x),
    .in_coord_y         (in_coord_y),
    .in_coord_z         (in_coord_z),
    .in_neighbour_count (in_neighbour_count),
    .point_count        (point_count_r),
    .cmd_valid          (cmd_valid),
    .cmd_pop            (cmd_pop),
    .cmd_op             (cmd_op),
    .cmd_index          (cmd_index),
    .cmd_x              (cmd_x),
    .cmd_y              (cmd_y),
    .cmd_z              (cmd_z),
    .cmd_k              (cmd_k)
  );

  knps_back #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_K      (MAX_K),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .point_count     (point_count_r),
    .cmd_valid       (cmd_valid),
    .cmd_pop         (cmd_pop),
    .cmd_op          (cmd_op),
    .cmd_index       (cmd_index),
    .cmd_x           (cmd_x),
    .cmd_y           (cmd_y),
    .cmd_z           (cmd_z),
    .cmd_k           (cmd_k),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found_index (out_found_index),
    .out_distance    (out_distance),
    .out_last        (out_last)
  );

endmodule

FILE: hdl/knps_checker.sv
// ---------------------------------------------------------------------------
// knps_props
// Port-level checks of the k-nearest point selector, bound to the top level.
// ---------------------------------------------------------------------------
module knps_props #(
  parameter int MAX_POINTS = 1024,
  parameter int MAX_K      = 16,
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [$clog2(MAX_POINTS+1)-1:0]     cfg_point_count,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                in_op,
  input  logic [$clog2(MAX_POINTS)-1:0]       in_point_index,
  input  logic signed [COORD_BITS-1:0]        in_coord_x,
  input  logic signed [COORD_BITS-1:0]        in_coord_y,
  input  logic signed [COORD_BITS-1:0]        in_coord_z,
  input  logic [$clog2(MAX_K+1)-1:0]          in_neighbour_count,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [$clog2(MAX_POINTS)-1:0]       out_found_index,
  input  logic [COORD_BITS:0]                 out_distance,
  input  logic                                out_last
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a held result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_found_index) && $stable(out_distance)
      && $stable(out_last))
    else $error("stalled result changed");

  // queue only fills on a transfer
  a_stall_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("input stall raised without a transfer");

  // reset leaves both channels quiet
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("channels active after reset");

endmodule

bind k_nearest_point_selector_core knps_props #(
  .MAX_POINTS (MAX_POINTS),
  .MAX_K      (MAX_K),
  .COORD_BITS (COORD_BITS)
) u_knps_props (.*);

FILE: dv/knps_checker.sv
// ---------------------------------------------------------------------------
// knps_checker
// Watches the configuration port and both channels of the k-nearest point
// selector, predicts every result from accepted transfers and compares.
// ---------------------------------------------------------------------------
module knps_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [10:0]        cfg_point_count,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_op,
  input  logic [9:0]         in_point_index,
  input  logic signed [15:0] in_coord_x,
  input  logic signed [15:0] in_coord_y,
  input  logic signed [15:0] in_coord_z,
  input  logic [4:0]         in_neighbour_count,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [9:0]         out_found_index,
  input  logic [16:0]        out_distance,
  input  logic               out_last,
  output int                 mismatches,
  output int                 pending,
  output int                 searches_seen,
  output int                 results_seen
);

  localparam int TABLE_DEPTH = 1024;
  localparam int K_LIMIT     = 16;

  typedef struct packed {
    logic [9:0]  found_index;
    logic [16:0] distance;
    logic        last;
  } neighbour_t;

  logic signed [15:0] table_x [TABLE_DEPTH];
  logic signed [15:0] table_y [TABLE_DEPTH];
  logic signed [15:0] table_z [TABLE_DEPTH];
  logic [10:0]        loaded_count;
  logic [9:0]         cand_index [K_LIMIT];
  logic [63:0]        cand_sq    [K_LIMIT];
  neighbour_t         expected_neighbours[$];

  assign pending = expected_neighbours.size();

  task automatic report_mismatch(input string msg);
    if (mismatches < 20)
      $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic logic [16:0] floor_root(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[16:0];
  endfunction

  function automatic logic [63:0] sq_to(input int i, input logic signed [15:0] qx,
                                        input logic signed [15:0] qy,
                                        input logic signed [15:0] qz);
    longint dx, dy, dz;
    dx = longint'(table_x[i]) - longint'(qx);
    dy = longint'(table_y[i]) - longint'(qy);
    dz = longint'(table_z[i]) - longint'(qz);
    return dx * dx + dy * dy + dz * dz;
  endfunction

  // swap when the lower slot is strictly closer, list kept worst first
  function automatic bit order_slots(input int j);
    logic [63:0] td;
    logic [9:0]  ti;
    if (cand_sq[j] < cand_sq[j+1]) begin
      td = cand_sq[j];   ti = cand_index[j];
      cand_sq[j] = cand_sq[j+1];   cand_index[j] = cand_index[j+1];
      cand_sq[j+1] = td; cand_index[j+1] = ti;
      return 1;
    end
    return 0;
  endfunction

  task automatic predict_nearest(input logic signed [15:0] qx, input logic signed [15:0] qy,
                                 input logic signed [15:0] qz, input logic [4:0] req);
    int n, k, j;
    logic [63:0] d;
    neighbour_t nb;
    n = (loaded_count > TABLE_DEPTH) ? TABLE_DEPTH : loaded_count;
    k = req;
    if (k > n) k = n;
    if (k > K_LIMIT) k = K_LIMIT;
    if (k == 0) return;
    for (int i = 0; i < k; i++) begin
      cand_index[i] = 10'(i);
      cand_sq[i] = sq_to(i, qx, qy, qz);
    end
    for (int i = 1; i < k; i++)
      for (int m = 0; m < k - i; m++)
        void'(order_slots(m));
    for (int i = k; i < n; i++) begin
      d = sq_to(i, qx, qy, qz);
      if (d < cand_sq[0]) begin
        cand_index[0] = 10'(i);
        cand_sq[0] = d;
        j = 0;
        while (j < k - 1 && order_slots(j)) j++;
      end
    end
    for (int i = 0; i < k; i++) begin
      nb.found_index = cand_index[k-1-i];
      nb.distance    = floor_root(cand_sq[k-1-i]);
      nb.last        = (i == k - 1);
      expected_neighbours.push_back(nb);
    end
  endtask

  always @(posedge clk) begin
    neighbour_t want;
    if (!rst_n) begin
      loaded_count = 0;
      for (int i = 0; i < K_LIMIT; i++) begin
        cand_index[i] = 0;
        cand_sq[i] = 0;
      end
    end else begin
      if (cfg_we) loaded_count = cfg_point_count;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_neighbours.size() == 0) begin
          report_mismatch($sformatf("unexpected result index %0d", out_found_index));
        end else begin
          want = expected_neighbours.pop_front();
          if (out_found_index !== want.found_index)
            report_mismatch($sformatf("found_index %0d, want %0d",
                                      out_found_index, want.found_index));
          if (out_distance !== want.distance)
            report_mismatch($sformatf("distance %0d, want %0d",
                                      out_distance, want.distance));
          if (out_last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", out_last, want.last));
        end
      end
      if (in_valid && !in_stall) begin
        if (in_op == knps_pkg::OP_WRITE) begin
          table_x[in_point_index] = in_coord_x;
          table_y[in_point_index] = in_coord_y;
          table_z[in_point_index] = in_coord_z;
        end else begin
          searches_seen++;
          predict_nearest(in_coord_x, in_coord_y, in_coord_z, in_neighbour_count);
        end
      end
    end
  end

  initial begin
    mismatches = 0;
    searches_seen = 0;
    results_seen = 0;
  end
endmodule

FILE: dv/k_nearest_point_selector_core_test.sv
// ---------------------------------------------------------------------------
// k_nearest_point_selector_core_test
// Loads point tables, runs nearest searches over several point counts with
// random idle and stall bursts, and lets the checker judge every result.
// ---------------------------------------------------------------------------
module k_nearest_point_selector_core_test;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [10:0] cfg_point_count = 0;
  logic in_valid = 0;
  logic in_stall;
  logic in_op = knps_pkg::OP_WRITE;
  logic [9:0] in_point_index = 0;
  logic signed [15:0] in_coord_x = 0;
  logic signed [15:0] in_coord_y = 0;
  logic signed [15:0] in_coord_z = 0;
  logic [4:0] in_neighbour_count = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [9:0] out_found_index;
  logic [16:0] out_distance;
  logic out_last;

  int mismatches, pending, searches_seen, results_seen;
  logic in_took = 0;
  bit quiet = 0;
  int stall_left = 0;
  int written = 0;

  always #10 clk = ~clk;

  k_nearest_point_selector_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_point_count(cfg_point_count),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_point_index(in_point_index), .in_coord_x(in_coord_x),
    .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .in_neighbour_count(in_neighbour_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_found_index(out_found_index), .out_distance(out_distance),
    .out_last(out_last)
  );

  knps_checker u_checker (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_point_count(cfg_point_count),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_point_index(in_point_index), .in_coord_x(in_coord_x),
    .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .in_neighbour_count(in_neighbour_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_found_index(out_found_index), .out_distance(out_distance),
    .out_last(out_last),
    .mismatches(mismatches), .pending(pending),
    .searches_seen(searches_seen), .results_seen(results_seen)
  );

  always @(posedge clk) in_took <= in_valid && !in_stall;

  // receiver stall bursts
  always @(negedge clk) begin
    if (quiet) begin
      out_stall = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) out_stall = 0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 18);
      out_stall = 1;
    end
  end

  function automatic logic signed [15:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send(input logic op, input logic [9:0] idx, input logic signed [15:0] x,
                      input logic signed [15:0] y, input logic signed [15:0] z,
                      input logic [4:0] k);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_op = op; in_point_index = idx;
    in_coord_x = x; in_coord_y = y; in_coord_z = z;
    in_neighbour_count = k;
    in_valid = 1;
    do @(negedge clk); while (!in_took);
  endtask

  task automatic write_point(input int idx);
    send(knps_pkg::OP_WRITE, 10'(idx), pick_coord(), pick_coord(), pick_coord(),
         5'($urandom));
  endtask

  task automatic search(input logic [4:0] k);
    send(knps_pkg::OP_SEARCH, 10'($urandom), pick_coord(), pick_coord(), pick_coord(), k);
  endtask

  // program point_count only once the block has drained
  task automatic set_point_count(input logic [10:0] value);
    in_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (1500) @(negedge clk);
    cfg_point_count = value;
    cfg_we = 1;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic fill_to(input int upto);
    while (written < upto) begin
      write_point(written);
      written++;
    end
  endtask

  initial begin
    int counts[8] = '{1, 2, 7, 16, 17, 40, 100, 3};
    repeat (4) @(negedge clk);
    rst_n = 1;

    // directed: extremes, duplicate points for ties, empty table
    set_point_count(0);
    send(knps_pkg::OP_SEARCH, 0, 0, 0, 0, 5);
    send(knps_pkg::OP_WRITE, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
    send(knps_pkg::OP_WRITE, 1, 16'sh8000, 16'sh8000, 16'sh8000, 31);
    send(knps_pkg::OP_WRITE, 2, 0, 0, 0, 0);
    send(knps_pkg::OP_WRITE, 3, 0, 0, 0, 0);
    send(knps_pkg::OP_WRITE, 4, 16'sh0003, 16'sh0004, 0, 0);
    send(knps_pkg::OP_WRITE, 5, 16'sh0000, 16'shfffb, 0, 0);
    send(knps_pkg::OP_WRITE, 6, 16'sh7fff, 16'sh8000, 16'sh7fff, 0);
    send(knps_pkg::OP_WRITE, 1023, 16'sh1234, 16'shedcb, 16'sh5a5a, 0);
    written = 7;
    set_point_count(7);
    send(knps_pkg::OP_SEARCH, 0, 0, 0, 0, 0);
    send(knps_pkg::OP_SEARCH, 1023, 0, 0, 0, 1);
    send(knps_pkg::OP_SEARCH, 0, 0, 0, 0, 7);
    send(knps_pkg::OP_SEARCH, 0, 16'sh8000, 16'sh8000, 16'sh8000, 16);
    send(knps_pkg::OP_SEARCH, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 31);
    send(knps_pkg::OP_SEARCH, 0, 16'sh0001, 16'sh0000, 0, 3);
    send(knps_pkg::OP_SEARCH, 0, 16'sh7fff, 16'sh8000, 16'sh8000, 17);

    // random phases over several table sizes
    fill_to(100);
    foreach (counts[p]) begin
      set_point_count(11'(counts[p]));
      repeat (30) begin
        if ($urandom_range(0, 9) < 4)
          write_point($urandom_range(0, 9) < 8 ? $urandom_range(0, 99) : $urandom_range(0, 1023));
        else
          search(5'($urandom_range(0, 9) < 8 ? $urandom_range(0, 20) : $urandom_range(0, 31)));
      end
    end

    // loaded table, no idling from here on
    quiet = 1;
    set_point_count(11'd100);
    repeat (3) search(16);
    search(0);
    search(31);
    search(16);
    in_valid = 0;

    while (pending != 0) @(negedge clk);
    repeat (1500) @(negedge clk);
    $display("ran %0d searches producing %0d neighbour results", searches_seen, results_seen);
    $display("point counts 0 to 100, k 0 to 31, coordinate extremes and ties");
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("TEST FAILED");
    $finish;
  end
endmodule

FILE: k_nearest_point_selector_core.f
hdl/knps_pkg.sv
hdl/knps_ram.sv
hdl/knps_front.sv
hdl/knps_back.sv
hdl/k_nearest_point_selector_core.sv
hdl/knps_checker.sv
dv/knps_checker.sv
dv/k_nearest_point_selector_core_test.sv
